FILE: rtl/scrb_pkg.sv
// scrb_pkg: shared types and constants of the scaled rotating bitmap blitter
// request and result structs, screen geometry, op codes, register indexes
// no dependencies
`default_nettype none

package scrb_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 400;
  localparam int SCREEN_HEIGHT = 300;
  localparam int MAX_SCALE     = 8;
  localparam int ROW_BYTES     = SCREEN_WIDTH / 8;
  localparam int FB_BYTES      = SCREEN_HEIGHT * ROW_BYTES;

  localparam int ADDR_W = $clog2(FB_BYTES);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int POS_W  = 14;  // signed pixel coordinate before clipping

  // op codes
  localparam logic [1:0] OP_IMAGE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_BPR       = 3'd2;
  localparam logic [2:0] REG_ROWS      = 3'd3;
  localparam logic [2:0] REG_SCALE     = 3'd4;
  localparam logic [2:0] REG_INVERT    = 3'd5;
  localparam logic [2:0] REG_ROTATE    = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  image_byte;
    logic [13:0] read_address;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       image_done;
  } out_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/scaled_rotating_bitmap_blitter.sv
// scaled_rotating_bitmap_blitter: 1 bit per pixel frame buffer with scaled,
// optionally rotated image blits, byte reads and screen clear
// depends on scrb_pkg
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+---------------------------------
//  request  | start, busy, in_req            | taken when start high, busy low
//  result   | out_valid, out_rsp             | one-cycle strobe, cannot stall
//  config   | psel penable pwrite paddr ...  | apb write on access phase
//
//  reset runs a clearing pass over all 15000 bytes of the frame buffer with busy
//  high, config writes are still taken during it
//  clear request: the same sweep, then the result strobe
//  read request: S_READ, then the registered result strobe
//  image byte: S_SETUP, S_BIT per source bit, then per painted pixel of a set bit's
//  s by s square (s the clamped scale) a read-modify-write: S_PADDR, S_PREAD, S_PWRITE
//  unused op code: result strobe in the cycle after the request, busy stays low
`default_nettype none

module scaled_rotating_bitmap_blitter
  import scrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire in_req_t     in_req,
  // result channel
  output logic             out_valid,
  output out_rsp_t         out_rsp,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SETUP,
    S_BIT,
    S_PADDR,
    S_PREAD,
    S_PWRITE
  } state_t;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [10:0] origin_x_r;
  logic [10:0] origin_y_r;
  logic [6:0]  bpr_r;
  logic [8:0]  rows_r;
  logic [3:0]  scale_r;
  logic        invert_r;
  logic        rotate_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      bpr_r      <= 7'd1;
      rows_r     <= 9'd1;
      scale_r    <= 4'd1;
      invert_r   <= 1'b0;
      rotate_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X: origin_x_r <= pwdata[10:0];
        REG_ORIGIN_Y: origin_y_r <= pwdata[10:0];
        REG_BPR:      bpr_r      <= pwdata[6:0];
        REG_ROWS:     rows_r     <= pwdata[8:0];
        REG_SCALE:    scale_r    <= pwdata[3:0];
        REG_INVERT:   invert_r   <= pwdata[0];
        REG_ROTATE:   rotate_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X: prdata = {21'd0, origin_x_r};
      REG_ORIGIN_Y: prdata = {21'd0, origin_y_r};
      REG_BPR:      prdata = {25'd0, bpr_r};
      REG_ROWS:     prdata = {23'd0, rows_r};
      REG_SCALE:    prdata = {28'd0, scale_r};
      REG_INVERT:   prdata = {31'd0, invert_r};
      REG_ROTATE:   prdata = {31'd0, rotate_r};
      default:      prdata = '0;
    endcase
  end

  // effective (saturated) settings
  logic [6:0] bpr_eff;
  logic [8:0] rows_eff;
  logic [3:0] scale_eff;

  always_comb begin
    if (bpr_r == 7'd0)       bpr_eff = 7'd1;
    else if (bpr_r > 7'd64)  bpr_eff = 7'd64;
    else                     bpr_eff = bpr_r;

    if (rows_r == 9'd0)        rows_eff = 9'd1;
    else if (rows_r > 9'd256)  rows_eff = 9'd256;
    else                       rows_eff = rows_r;

    if (scale_r == 4'd0)                   scale_eff = 4'd1;
    else if (scale_r > 4'(MAX_SCALE))      scale_eff = 4'(MAX_SCALE);
    else                                   scale_eff = scale_r;
  end

  // ------------------------------------------------------------------
  // frame buffer: single write port, one registered read port
  // ------------------------------------------------------------------
  logic [7:0]        fb_mem [FB_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fb_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= fb_mem[mem_raddr];
  end

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic                     clr_reply_r, clr_reply_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  logic [7:0]               shift_r, shift_nxt;     // source bits, msb is current pixel
  logic [2:0]               bit_cnt_r, bit_cnt_nxt;
  logic [2:0]               fy_r, fy_nxt;
  logic [2:0]               fx_r, fx_nxt;
  logic [3:0]               s_r, s_nxt;
  logic signed [POS_W-1:0]  row_base_r, row_base_nxt;
  logic signed [POS_W-1:0]  bit_col_r, bit_col_nxt;  // left column of current square
  logic signed [POS_W-1:0]  cur_row_r, cur_row_nxt;
  logic signed [POS_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic [7:0]               mask_r, mask_nxt;
  logic                     hit_r, hit_nxt;
  logic                     done_r, done_nxt;
  logic [7:0]               src_row_r, src_row_nxt;
  logic [5:0]               src_col_r, src_col_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_rsp_t                 out_rsp_r, out_rsp_nxt;

  logic                     accept;
  logic                     rd_in_range;
  logic [2:0]               s_m1;
  logic [11:0]              row_prod;
  logic [12:0]              col_prod;
  logic signed [POS_W-1:0]  oy_ext, ox_ext;
  logic signed [POS_W:0]    pr, pc;
  logic                     on_screen;

  assign busy        = (state_r != S_IDLE);
  assign accept      = start & ~busy;
  assign rd_in_range = (in_req.read_address < ADDR_W'(FB_BYTES));
  assign s_m1        = 3'(s_r - 4'd1);

  // square origin of the byte being drawn
  assign row_prod = 12'(src_row_r) * 12'(scale_eff);
  assign col_prod = 13'({src_col_r, 3'b000}) * 13'(scale_eff);
  assign oy_ext   = {{(POS_W-11){origin_y_r[10]}}, origin_y_r};
  assign ox_ext   = {{(POS_W-11){origin_x_r[10]}}, origin_x_r};

  // screen position of the current pixel, with optional rotation
  always_comb begin
    if (rotate_r) begin
      pr = (POS_W+1)'(SCREEN_WIDTH - 1) - {cur_col_r[POS_W-1], cur_col_r};
      pc = {cur_row_r[POS_W-1], cur_row_r};
    end else begin
      pr = {cur_row_r[POS_W-1], cur_row_r};
      pc = {cur_col_r[POS_W-1], cur_col_r};
    end
    on_screen = !pr[POS_W] && (pr < (POS_W+1)'(SCREEN_HEIGHT)) &&
                !pc[POS_W] && (pc < (POS_W+1)'(SCREEN_WIDTH));
  end

  assign mem_raddr = (state_r == S_IDLE) ?
                     (rd_in_range ? in_req.read_address[ADDR_W-1:0] : '0) : addr_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    rd_ok_nxt     = rd_ok_r;
    shift_nxt     = shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    fy_nxt        = fy_r;
    fx_nxt        = fx_r;
    s_nxt         = s_r;
    row_base_nxt  = row_base_r;
    bit_col_nxt   = bit_col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    addr_nxt      = addr_r;
    mask_nxt      = mask_r;
    hit_nxt       = hit_r;
    done_nxt      = done_r;
    src_row_nxt   = src_row_r;
    src_col_nxt   = src_col_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;

    case (state_r)
      S_CLEAR: begin
        // one byte per cycle over the whole buffer
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == ADDR_W'(FB_BYTES - 1)) begin
          state_nxt     = S_IDLE;
          clr_addr_nxt  = '0;
          out_valid_nxt = clr_reply_r;
          out_rsp_nxt   = '0;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_req.op)
            OP_IMAGE: begin
              shift_nxt = in_req.image_byte;
              state_nxt = S_SETUP;
            end
            OP_READ: begin
              rd_ok_nxt = rd_in_range;
              state_nxt = S_READ;
            end
            OP_CLEAR: begin
              clr_addr_nxt  = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLEAR;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = '0;
            end
          endcase
        end
      end

      S_READ: begin
        out_valid_nxt         = 1'b1;
        out_rsp_nxt.read_data = rd_ok_r ? rdata_r : 8'd0;
        out_rsp_nxt.image_done = 1'b0;
        state_nxt             = S_IDLE;
      end

      S_SETUP: begin
        // latch the byte's square origin, then step the source position
        s_nxt        = scale_eff;
        bit_cnt_nxt  = '0;
        row_base_nxt = oy_ext + $signed({2'b00, row_prod});
        bit_col_nxt  = ox_ext + $signed({1'b0, col_prod});
        done_nxt     = 1'b0;
        if ({1'b0, src_col_r} >= bpr_eff - 7'd1) begin
          src_col_nxt = '0;
          if ({1'b0, src_row_r} >= rows_eff - 9'd1) begin
            src_row_nxt = '0;
            done_nxt    = 1'b1;
          end else begin
            src_row_nxt = src_row_r + 8'd1;
          end
        end else begin
          src_col_nxt = src_col_r + 6'd1;
        end
        state_nxt = S_BIT;
      end

      S_BIT: begin
        if (shift_r[7]) begin
          fy_nxt      = '0;
          fx_nxt      = '0;
          cur_row_nxt = row_base_r;
          cur_col_nxt = bit_col_r;
          state_nxt   = S_PADDR;
        end else if (bit_cnt_r == 3'd7) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{read_data: 8'd0, image_done: done_r};
          state_nxt     = S_IDLE;
        end else begin
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_col_nxt = bit_col_r + POS_W'(s_r);
        end
      end

      S_PADDR: begin
        hit_nxt   = on_screen;
        addr_nxt  = ADDR_W'(pr[ROW_W-1:0] * ROW_BYTES) + ADDR_W'(pc[COL_W-1:3]);
        mask_nxt  = 8'h80 >> pc[2:0];
        state_nxt = S_PREAD;
      end

      S_PREAD: begin
        state_nxt = S_PWRITE;
      end

      S_PWRITE: begin
        mem_we    = hit_r;
        mem_waddr = addr_r;
        mem_wdata = invert_r ? (rdata_r & ~mask_r) : (rdata_r | mask_r);
        if (fx_r != s_m1) begin
          fx_nxt      = fx_r + 3'd1;
          cur_col_nxt = cur_col_r + POS_W'(1);
          state_nxt   = S_PADDR;
        end else if (fy_r != s_m1) begin
          fx_nxt      = '0;
          fy_nxt      = fy_r + 3'd1;
          cur_row_nxt = cur_row_r + POS_W'(1);
          cur_col_nxt = bit_col_r;
          state_nxt   = S_PADDR;
        end else if (bit_cnt_r == 3'd7) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{read_data: 8'd0, image_done: done_r};
          state_nxt     = S_IDLE;
        end else begin
          // square finished, move on to the next source bit
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_col_nxt = bit_col_r + POS_W'(s_r);
          state_nxt   = S_BIT;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      src_row_r   <= '0;
      src_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      src_row_r   <= src_row_nxt;
      src_col_r   <= src_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_ok_r    <= rd_ok_nxt;
    shift_r    <= shift_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    fy_r       <= fy_nxt;
    fx_r       <= fx_nxt;
    s_r        <= s_nxt;
    row_base_r <= row_base_nxt;
    bit_col_r  <= bit_col_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    hit_r      <= hit_nxt;
    done_r     <= done_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // an accepted request either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted request neither busy nor answered");

  // image completion never carries read data
  a_done_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.image_done) |-> (out_rsp.read_data == 8'd0))
    else $error("image_done with non-zero read_data");

  // frame buffer writes stay inside the buffer
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_waddr < ADDR_W'(FB_BYTES)))
    else $error("frame buffer write out of range");

  // pixel writes only follow the read of the same byte
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PWRITE) |-> ($past(state_r) == S_PREAD))
    else $error("pixel write without preceding read");

endmodule

`default_nettype wire
